FILE: rtl/hight_block_decrypt_top_defines.svh
// Assertion macros shared by the HIGHT decryption RTL.
`ifndef HIGHT_BLOCK_DECRYPT_TOP_DEFINES_SVH
`define HIGHT_BLOCK_DECRYPT_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbd assertion failed");

// Next-cycle implication, disabled during reset.
`define HBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbd assertion failed");

`endif

FILE: rtl/hbd_pkg.sv
package hbd_pkg;

   typedef logic [7:0] octet_type;

   // Byte i of a block sits at index i.
   typedef logic [7:0][7:0]  blk_type;
   typedef logic [15:0][7:0] mkey_type;
   typedef logic [3:0][7:0]  quad_type;

   localparam int unsigned ROUND_COUNT = 32;
   localparam int unsigned ROUND_W     = $clog2(ROUND_COUNT);

   // Configuration register indexes.
   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   // Control from the sequencer to the key schedule.
   typedef struct packed {
      logic load;
      logic step;
   } ks_ctrl_type;

endpackage

FILE: rtl/hbd_if.sv
interface hbd_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] ciphertext;

   modport source (output valid, output ciphertext, input ready);
   modport sink   (input valid, input ciphertext, output ready);
endinterface

interface hbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] plaintext;

   modport source (output valid, output plaintext, input ready);
   modport sink   (input valid, input plaintext, output ready);
endinterface

FILE: rtl/hbd_keysched.sv
`include "hight_block_decrypt_top_defines.svh"

module hbd_keysched (
   input  logic                 clock,
   input  logic                 reset,
   input  hbd_pkg::ks_ctrl_type ctrl,
   input  hbd_pkg::mkey_type    mkey,
   output hbd_pkg::quad_type    subkey,
   output logic                 last
);

   function automatic logic [6:0] lfsr_fwd(input logic [6:0] d);
      lfsr_fwd = {d[3] ^ d[0], d[6:1]};
   endfunction

   function automatic logic [6:0] lfsr_back(input logic [6:0] n);
      lfsr_back = {n[5:0], n[6] ^ n[2]};
   endfunction

   function automatic logic [6:0] delta_after(input int unsigned steps);
      logic [6:0] d;
      d = 7'h5A;
      for (int unsigned i = 0; i < steps; i++) begin
         d = lfsr_fwd(d);
      end
      delta_after = d;
   endfunction

   localparam int unsigned SUBKEYS = 4 * hbd_pkg::ROUND_COUNT;
   // The highest group of four subkeys is used first.
   localparam logic [6:0] START_DELTA = delta_after(SUBKEYS - 4);

   logic [hbd_pkg::ROUND_W-1:0] grp_ff, grp_in;
   logic [6:0]                  delta_ff, delta_in;
   logic [3:0][6:0]             dl;

   always_comb begin
      dl[0] = delta_ff;
      for (int j = 1; j < 4; j++) begin
         dl[j] = lfsr_fwd(dl[j-1]);
      end
   end

   // Subkey index k = 4*grp + j selects master key byte
   // {k[3], (k[2:0] - k[6:4]) mod 8}.
   always_comb begin
      logic [2:0] pos;
      logic [2:0] low;
      for (int j = 0; j < 4; j++) begin
         pos = {grp_ff[0], 2'(j)};
         low = pos - grp_ff[4:2];
         subkey[j] = mkey[{grp_ff[1], low}] + {1'b0, dl[j]};
      end
   end

   assign last = (grp_ff == '0);

   always_comb begin
      grp_in   = grp_ff;
      delta_in = delta_ff;
      priority if (ctrl.load) begin
         grp_in   = '1;
         delta_in = START_DELTA;
      end else if (ctrl.step) begin
         grp_in   = grp_ff - 1'b1;
         delta_in = lfsr_back(lfsr_back(lfsr_back(lfsr_back(delta_ff))));
      end else begin
         grp_in   = grp_ff;
         delta_in = delta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff   <= '0;
         delta_ff <= '0;
      end else begin
         grp_ff   <= grp_in;
         delta_ff <= delta_in;
      end
   end

   `HBD_ASSERT_NEXT(a_ks_load, clock, reset, ctrl.load, (grp_ff == '1) && (delta_ff == START_DELTA))
   `HBD_ASSERT_NEXT(a_ks_step, clock, reset, !ctrl.load && ctrl.step, grp_ff == $past(grp_ff) - 1'b1)

endmodule

FILE: rtl/hbd_round.sv
module hbd_round (
   input  hbd_pkg::blk_type  x,
   input  hbd_pkg::quad_type subkey,
   input  hbd_pkg::quad_type wkey,
   input  logic              last,
   output hbd_pkg::blk_type  y
);

   function automatic hbd_pkg::octet_type mix0(input hbd_pkg::octet_type v);
      mix0 = {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[0], v[7:1]};
   endfunction

   function automatic hbd_pkg::octet_type mix1(input hbd_pkg::octet_type v);
      mix1 = {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]} ^ {v[1:0], v[7:2]};
   endfunction

   hbd_pkg::octet_type t0, t1, t2, t3;

   // Inverse round terms for the odd bytes.
   assign t0 = x[1] - (mix1(x[0]) ^ subkey[0]);
   assign t1 = x[3] ^ (mix0(x[2]) + subkey[1]);
   assign t2 = x[5] - (mix1(x[4]) ^ subkey[2]);
   assign t3 = x[7] ^ (mix0(x[6]) + subkey[3]);

   always_comb begin
      if (last) begin
         // No rotation, and the output whitening folds in.
         y[0] = x[0] - wkey[0];
         y[1] = t0;
         y[2] = x[2] ^ wkey[1];
         y[3] = t1;
         y[4] = x[4] - wkey[2];
         y[5] = t2;
         y[6] = x[6] ^ wkey[3];
         y[7] = t3;
      end else begin
         y[0] = t0;
         y[1] = x[2];
         y[2] = t1;
         y[3] = x[4];
         y[4] = t2;
         y[5] = x[6];
         y[6] = t3;
         y[7] = x[0];
      end
   end

endmodule

FILE: rtl/hight_block_decrypt_top.sv
// HIGHT block decryption, 64-bit block under a 128-bit master key.
// The key is written through the csr_ port: index 0 holds key bytes 0 to 7,
// index 1 holds bytes 8 to 15. Writes take effect at the clock edge where
// csr_wr_en is high and should only be made while the block is idle.
// Ciphertext blocks arrive on the req_chan channel and plaintext leaves on
// rsp_chan; each channel moves one block per valid/ready transfer.
// A block is whitened as it is taken in, then one shared round unit runs
// once per cycle, driven by a key schedule that regenerates the subkeys in
// reverse order. The output whitening is folded into the last round, which
// writes the output register directly. The input is not ready while a block
// is in the round loop. If the receiver stalls and the output register is
// still full, the last round waits until it drains. A finished result
// waiting in the output register does not block the next input transfer.
// Synchronous reset returns the sequencer to idle, empties the output
// register and clears both key registers to zero.
`include "hight_block_decrypt_top_defines.svh"

module hight_block_decrypt_top (
   input  logic              clock,
   input  logic              reset,
   hbd_req_if.sink           req_chan,
   hbd_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic [0:0]        csr_index,
   input  logic [63:0]       csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [63:0]          key_low_ff, key_low_in;
   logic [63:0]          key_high_ff, key_high_in;
   hbd_pkg::blk_type     blk_ff, blk_in;
   hbd_pkg::blk_type     out_ff, out_in;
   logic                 out_valid_ff, out_valid_in;

   hbd_pkg::mkey_type    mkey;
   hbd_pkg::blk_type     cin;
   hbd_pkg::blk_type     whitened;
   hbd_pkg::blk_type     round_out;
   hbd_pkg::quad_type    subkey;
   hbd_pkg::quad_type    wkey;
   hbd_pkg::ks_ctrl_type ks_ctrl;
   logic                 ks_last;
   logic                 take;
   logic                 finish;
   logic                 advance;

   assign mkey = {key_high_ff, key_low_ff};
   assign wkey = {mkey[15], mkey[14], mkey[13], mkey[12]};
   assign cin  = req_chan.ciphertext;

   // Input whitening undoes the final whitening of encryption.
   always_comb begin
      whitened    = cin;
      whitened[0] = cin[0] - mkey[0];
      whitened[2] = cin[2] ^ mkey[1];
      whitened[4] = cin[4] - mkey[2];
      whitened[6] = cin[6] ^ mkey[3];
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign take           = req_chan.valid && req_chan.ready;

   // The last round completes only when the output register can take it.
   assign finish  = (state_ff == ST_RUN) && ks_last && (!out_valid_ff || rsp_chan.ready);
   assign advance = (state_ff == ST_RUN) && (!ks_last || finish);

   assign ks_ctrl.load = take;
   assign ks_ctrl.step = advance;

   hbd_keysched u_keysched (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ks_ctrl),
      .mkey   (mkey),
      .subkey (subkey),
      .last   (ks_last)
   );

   hbd_round u_round (
      .x      (blk_ff),
      .subkey (subkey),
      .wkey   (wkey),
      .last   (ks_last),
      .y      (round_out)
   );

   always_comb begin
      state_in = state_ff;
      blk_in   = blk_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               blk_in   = whitened;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (advance) begin
               blk_in = round_out;
            end
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      priority if (finish) begin
         out_in       = round_out;
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_comb begin
      key_low_in  = key_low_ff;
      key_high_in = key_high_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            hbd_pkg::CSR_KEY_LOW:  key_low_in  = csr_wdata;
            hbd_pkg::CSR_KEY_HIGH: key_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.plaintext = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         key_low_ff   <= key_low_in;
         key_high_ff  <= key_high_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      out_ff <= out_in;
   end

   `HBD_ASSERT_NEXT(a_take_busy, clock, reset, take, !req_chan.ready && !ks_last)
   `HBD_ASSERT_NEXT(a_run_holds, clock, reset, (state_ff == ST_RUN) && !ks_last, state_ff == ST_RUN)
   `HBD_ASSERT_NEXT(a_finish_out, clock, reset, finish, rsp_chan.valid && req_chan.ready)
   `HBD_ASSERT_NOW(a_finish_room, clock, reset, finish && out_valid_ff, rsp_chan.ready)

endmodule
